FILE: src/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst is high
`define AKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define AKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/akd_pkg.sv
// Types and constants for the ADC ladder key debouncer
package akd_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int MAX_GROUP = 64;
  localparam int CNT_W     = 7;
  localparam int SUM_W     = 18;
  localparam int DEB_W     = 8;
  localparam int KEY_W     = 2;
  localparam int IDX_W     = 3;
  localparam int STEP_W    = 5;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_BAND_TOP     = 3'd0,
    REG_MID_BAND_BOTTOM  = 3'd1,
    REG_MID_BAND_TOP     = 3'd2,
    REG_HIGH_BAND_BOTTOM = 3'd3,
    REG_HIGH_BAND_TOP    = 3'd4,
    REG_SAMPLES_PER_POLL = 3'd5,
    REG_DEBOUNCE_NEEDED  = 3'd6
  } reg_idx_t;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE = 2'd0,
    KEY_1    = 2'd1,
    KEY_2    = 2'd2,
    KEY_3    = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

FILE: src/adc_ladder_key_debouncer.sv
// Top level: sample averaging, ladder classification and key debounce
// One converter word is taken per cycle while a group fills. The word that
// closes a group starts a restoring divide of the 18-bit sum by the good
// sample count, one quotient bit per cycle through a single shared
// subtract-and-compare unit, so a closing word occupies the block for an
// accept step, a divide step per quotient bit and a classify and debounce
// step; a group with no good samples skips the divide. The result sits in an
// output register, so a stalled master side holds only the finishing step;
// new words are still taken while the result waits there.
module adc_ladder_key_debouncer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] sample_value
  input  logic        s_axis_tuser,  // [0] sample_ok
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [1:0] stable_key, [13:2] average_value
  output logic        m_axis_tuser,  // [0] average_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [akd_pkg::STEP_W-1:0] DIV_LAST = akd_pkg::STEP_W'(akd_pkg::SUM_W - 1);
  localparam logic [akd_pkg::CNT_W-1:0]  GRP_MAX  = akd_pkg::CNT_W'(akd_pkg::MAX_GROUP);

  // configuration
  logic [akd_pkg::SAMPLE_W-1:0] low_band_top, mid_band_bottom, mid_band_top;
  logic [akd_pkg::SAMPLE_W-1:0] high_band_bottom, high_band_top;
  logic [akd_pkg::CNT_W-1:0]    samples_per_poll;
  logic [akd_pkg::DEB_W-1:0]    debounce_needed;

  // state
  akd_pkg::state_t              state, state_next;
  logic [akd_pkg::SUM_W-1:0]    sample_sum;
  logic [akd_pkg::CNT_W-1:0]    samples_seen, good_samples;
  logic [akd_pkg::CNT_W-1:0]    rem;
  logic [akd_pkg::STEP_W-1:0]   div_cnt;
  akd_pkg::key_t                debounced_key, pending_key;
  logic [akd_pkg::DEB_W-1:0]    pending_count;

  // control
  logic in_fire, grp_end, fin_fire, div_done;
  logic [akd_pkg::CNT_W-1:0]    grp_len, seen_inc, good_inc;

  // divide step
  logic [akd_pkg::CNT_W-1:0]    rem_shift, rem_sub;
  logic                         rem_ge;

  // finish
  logic [akd_pkg::SAMPLE_W-1:0] avg;
  akd_pkg::key_t                cls_key, deb_next, pend_next;
  logic [akd_pkg::DEB_W-1:0]    cnt_next, cnt_inc, needed;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_band_top     <= 12'd500;
      mid_band_bottom  <= 12'd1200;
      mid_band_top     <= 12'd1800;
      high_band_bottom <= 12'd2400;
      high_band_top    <= 12'd3200;
      samples_per_poll <= 7'd8;
      debounce_needed  <= 8'd3;
    end else if (cfg_we) begin
      case (akd_pkg::reg_idx_t'(cfg_index))
        akd_pkg::REG_LOW_BAND_TOP:     low_band_top     <= cfg_data;
        akd_pkg::REG_MID_BAND_BOTTOM:  mid_band_bottom  <= cfg_data;
        akd_pkg::REG_MID_BAND_TOP:     mid_band_top     <= cfg_data;
        akd_pkg::REG_HIGH_BAND_BOTTOM: high_band_bottom <= cfg_data;
        akd_pkg::REG_HIGH_BAND_TOP:    high_band_top    <= cfg_data;
        akd_pkg::REG_SAMPLES_PER_POLL: samples_per_poll <= cfg_data[akd_pkg::CNT_W-1:0];
        akd_pkg::REG_DEBOUNCE_NEEDED:  debounce_needed  <= cfg_data[akd_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // group bookkeeping
  always_comb begin
    if (samples_per_poll == '0) begin
      grp_len = akd_pkg::CNT_W'(1);
    end else if (samples_per_poll > GRP_MAX) begin
      grp_len = GRP_MAX;
    end else begin
      grp_len = samples_per_poll;
    end
    seen_inc = samples_seen + akd_pkg::CNT_W'(1);
    good_inc = good_samples + akd_pkg::CNT_W'(s_axis_tuser);
    grp_end  = seen_inc >= grp_len;
  end

  // shared subtract-and-compare unit
  always_comb begin
    rem_shift = {rem[akd_pkg::CNT_W-2:0], sample_sum[akd_pkg::SUM_W-1]};
    rem_ge    = rem_shift >= good_samples;
    rem_sub   = rem_shift - good_samples;
  end

  // classification and debounce
  always_comb begin
    avg = sample_sum[akd_pkg::SAMPLE_W-1:0];
    if (avg < low_band_top) begin
      cls_key = akd_pkg::KEY_3;
    end else if (avg >= mid_band_bottom && avg < mid_band_top) begin
      cls_key = akd_pkg::KEY_2;
    end else if (avg >= high_band_bottom && avg < high_band_top) begin
      cls_key = akd_pkg::KEY_1;
    end else begin
      cls_key = akd_pkg::KEY_NONE;
    end
    cnt_inc = (pending_count == '1) ? pending_count : pending_count + akd_pkg::DEB_W'(1);
    needed  = (debounce_needed == '0) ? akd_pkg::DEB_W'(1) : debounce_needed;
    deb_next  = debounced_key;
    pend_next = pending_key;
    cnt_next  = pending_count;
    if (good_samples != '0) begin
      if (cls_key == debounced_key) begin
        pend_next = akd_pkg::KEY_NONE;
        cnt_next  = '0;
      end else if (cls_key != pending_key) begin
        pend_next = cls_key;
        cnt_next  = akd_pkg::DEB_W'(1);
      end else if (cnt_inc >= needed) begin
        deb_next  = cls_key;
        pend_next = akd_pkg::KEY_NONE;
        cnt_next  = '0;
      end else begin
        cnt_next  = cnt_inc;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      akd_pkg::ST_IDLE: begin
        if (in_fire && grp_end) begin
          state_next = (good_inc != '0) ? akd_pkg::ST_DIV : akd_pkg::ST_FIN;
        end
      end
      akd_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = akd_pkg::ST_FIN;
        end
      end
      akd_pkg::ST_FIN: begin
        if (fin_fire) begin
          state_next = akd_pkg::ST_IDLE;
        end
      end
      default: state_next = akd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_done      = 1'b0;
    fin_fire      = 1'b0;
    case (state)
      akd_pkg::ST_IDLE: s_axis_tready = 1'b1;
      akd_pkg::ST_DIV:  div_done      = div_cnt == DIV_LAST;
      akd_pkg::ST_FIN:  fin_fire      = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
    in_fire = s_axis_tvalid && s_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= akd_pkg::ST_IDLE;
      sample_sum    <= '0;
      samples_seen  <= '0;
      good_samples  <= '0;
      rem           <= '0;
      div_cnt       <= '0;
      debounced_key <= akd_pkg::KEY_NONE;
      pending_key   <= akd_pkg::KEY_NONE;
      pending_count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (s_axis_tuser) begin
          sample_sum <= sample_sum + akd_pkg::SUM_W'(s_axis_tdata[akd_pkg::SAMPLE_W-1:0]);
        end
        good_samples <= good_inc;
        samples_seen <= seen_inc;
        rem          <= '0;
        div_cnt      <= '0;
      end
      if (state == akd_pkg::ST_DIV) begin
        rem        <= rem_ge ? rem_sub : rem_shift;
        sample_sum <= {sample_sum[akd_pkg::SUM_W-2:0], rem_ge};
        div_cnt    <= div_cnt + akd_pkg::STEP_W'(1);
      end
      if (fin_fire) begin
        debounced_key <= deb_next;
        pending_key   <= pend_next;
        pending_count <= cnt_next;
        sample_sum    <= '0;
        samples_seen  <= '0;
        good_samples  <= '0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result word; payload needs no reset
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      m_axis_tdata <= {2'b00, (good_samples != '0) ? avg : '0, deb_next};
      m_axis_tuser <= good_samples != '0;
    end
  end

endmodule

FILE: src/akd_checker.sv
// Port checker for the ADC ladder key debouncer, bound to the top level
`include "assert_macros.svh"

module akd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `AKD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")
  `AKD_ASSERT(a_empty_avg_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[13:2] == 12'd0), "empty group carries a nonzero average")
  `AKD_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared one cycle after a word")

endmodule

bind adc_ladder_key_debouncer akd_checker u_akd_checker (.*);
